### rtl/dpsm_pkg.sv
// shared types, constants and the status word table of the drive profile state machine
package dpsm_pkg;

   // field widths
   localparam int CwWidth     = 16;
   localparam int StatusWidth = 16;
   localparam int ModeWidth   = 8;
   localparam int RspWidth    = 32;

   // control word bit positions
   localparam int CwBitSwitchOn = 0;
   localparam int CwBitVoltage  = 1;
   localparam int CwBitQstop    = 2;
   localparam int CwBitOperate  = 3;
   localparam int CwBitReset    = 7;

   // command patterns
   localparam logic [CwWidth-1:0] CMD_SHUTDOWN = 16'h0006;
   localparam logic [CwWidth-1:0] CMD_SWITCHON = 16'h0007;
   localparam logic [CwWidth-1:0] CMD_ENABLEOP = 16'h000F;

   // request kinds carried in tuser
   localparam logic REQ_STEP  = 1'b0;
   localparam logic REQ_FAULT = 1'b1;

   typedef enum logic [2:0] {
      ST_NOTREADY = 3'd0,
      ST_DISABLED = 3'd1,
      ST_READY    = 3'd2,
      ST_ON       = 3'd3,
      ST_ENABLED  = 3'd4,
      ST_QSTOP    = 3'd5,
      ST_REACTION = 3'd6,
      ST_FAULT    = 3'd7
   } drive_state_type;

   // one step transaction handed to the core
   typedef struct packed {
      logic               valid;
      logic               cmd;
      logic [CwWidth-1:0] control_word;
   } step_req_type;

   // one result as produced by the core
   typedef struct packed {
      logic signed [ModeWidth-1:0] active_mode;
      logic                        output_enabled;
      drive_state_type             drive_state;
      logic [StatusWidth-1:0]      status_word;
   } result_type;

   // true when every pattern bit is set in the control word
   function automatic logic has_cmd(input logic [CwWidth-1:0] cw,
                                    input logic [CwWidth-1:0] pat);
      has_cmd = ((cw & pat) == pat);
   endfunction

   // status word for each state
   function automatic logic [StatusWidth-1:0] status_of(input drive_state_type st);
      logic [StatusWidth-1:0] sw;
      unique case (st)
         ST_NOTREADY: sw = 16'h0000;
         ST_DISABLED: sw = 16'h0050;
         ST_READY:    sw = 16'h0011;
         ST_ON:       sw = 16'h0013;
         ST_ENABLED:  sw = 16'h0017;
         ST_QSTOP:    sw = 16'h0017;
         ST_REACTION: sw = 16'h0018;
         ST_FAULT:    sw = 16'h0048;
      endcase
      status_of = sw;
   endfunction

endpackage

### rtl/drive_profile_state_machine_top.sv
// top level of the drive profile state machine: stream channels and result skid buffer
//
// Usage:
//   req_ channel: one transaction per control word step or fault event.
//     req_tuser is the kind (0 step, 1 raise fault), req_tdata the control word.
//   rsp_ channel: one result per request transaction, in order, carrying the
//     status word, the drive state code, the output enable flag and the mode echo.
//   csr_we / csr_wdata write the mode of operation register, echoed in every result.
// Throughput: one transaction per cycle while req_tready is high; the state
//   update is a single pass of the next-state logic between the state register
//   and the result register.
// Reset: synchronous; the drive starts in switch on disabled, the fault reset
//   edge detector is cleared, the mode register reads 0 and no result is pending.
// Stall: a two-entry output stage (result register plus skid register) keeps
//   req_tready high while one result waits; with both full req_tready drops
//   until rsp_tready takes a result.
module drive_profile_state_machine_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] control_word
   input  logic        req_tuser,   // [0] cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [dpsm_pkg::RspWidth-1:0] rsp_tdata,
                                    // [15:0] status_word, [18:16] drive_state,
                                    // [19] output_enabled, [27:20] active_mode, [31:28] zero
   // configuration
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);
   import dpsm_pkg::*;

   step_req_type step;
   result_type   result;

   logic       req_accept, rsp_take;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_take   = out_valid_ff && rsp_tready;

   assign step.valid        = req_accept;
   assign step.cmd          = req_tuser;
   assign step.control_word = req_tdata;

   dpsm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (signed'(csr_wdata)),
      .step      (step),
      .result    (result)
   );

   // output stage next values
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_accept;
            out_data_in  = result;
         end
      end else if (req_accept) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   // output stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // output stage payload
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // result packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        out_data_ff.active_mode,
                        out_data_ff.output_enabled,
                        out_data_ff.drive_state,
                        out_data_ff.status_word};

   // skid entry only ever sits behind a full result register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a result in the output register");

   // a transaction taken into an empty output stage shows up next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !out_valid_ff) |=> rsp_tvalid)
      else $error("result missing after accepted transaction");

   // the output enable flag agrees with the state code
   a_enable_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_data_ff.output_enabled == (out_data_ff.drive_state == ST_ENABLED)))
      else $error("output enable flag disagrees with drive state");

endmodule

### rtl/dpsm_core.sv
// power state register, fault reset edge detector, mode register and result logic
module dpsm_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic signed [dpsm_pkg::ModeWidth-1:0] csr_wdata,
   input  dpsm_pkg::step_req_type              step,
   output dpsm_pkg::result_type                result
);
   import dpsm_pkg::*;

   drive_state_type             state_ff, state_in;
   logic                        prior_rst_ff, prior_rst_in;
   logic signed [ModeWidth-1:0] mode_ff;

   logic [CwWidth-1:0] cw;
   logic               volt_off, qstop_on, rst_bit;

   assign cw       = step.control_word;
   assign volt_off = !cw[CwBitVoltage];
   assign qstop_on = !cw[CwBitQstop];
   assign rst_bit  = cw[CwBitReset];

   // next state
   always_comb begin
      state_in     = state_ff;
      prior_rst_in = prior_rst_ff;
      if (step.cmd == REQ_FAULT) begin
         state_in = ST_REACTION;
      end else begin
         prior_rst_in = rst_bit;
         unique case (state_ff)
            ST_NOTREADY: state_in = ST_NOTREADY;
            ST_DISABLED: begin
               if (has_cmd(cw, CMD_SHUTDOWN)) state_in = ST_READY;
            end
            ST_READY: begin
               priority if (volt_off) state_in = ST_DISABLED;
               else if (has_cmd(cw, CMD_SWITCHON)) state_in = ST_ON;
            end
            ST_ON: begin
               priority if (volt_off) state_in = ST_DISABLED;
               else if (qstop_on) state_in = ST_QSTOP;
               else if (has_cmd(cw, CMD_ENABLEOP)) state_in = ST_ENABLED;
            end
            ST_ENABLED: begin
               priority if (volt_off) state_in = ST_DISABLED;
               else if (qstop_on) state_in = ST_QSTOP;
               else if (!cw[CwBitOperate]) state_in = ST_ON;
            end
            ST_QSTOP: begin
               priority if (volt_off) state_in = ST_DISABLED;
               else if (has_cmd(cw, CMD_ENABLEOP)) state_in = ST_ENABLED;
            end
            ST_REACTION: state_in = ST_FAULT;
            ST_FAULT: begin
               if (rst_bit && !prior_rst_ff) state_in = ST_DISABLED;
            end
         endcase
      end
   end

   // result for the transaction being taken
   always_comb begin
      result.status_word    = status_of(state_in);
      result.drive_state    = state_in;
      result.output_enabled = (state_in == ST_ENABLED);
      result.active_mode    = mode_ff;
   end

   // state update on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DISABLED;
         prior_rst_ff <= 1'b0;
      end else if (step.valid) begin
         state_ff     <= state_in;
         prior_rst_ff <= prior_rst_in;
      end
   end

   // mode of operation register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // not ready is never entered after reset
   a_never_notready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_NOTREADY)
      else $error("drive state entered not ready");

   // a fault transaction always lands in fault reaction
   a_fault_reaction: assert property (@(posedge clock) disable iff (reset)
      (step.valid && step.cmd == REQ_FAULT) |=> (state_ff == ST_REACTION))
      else $error("fault transaction did not reach fault reaction");

   // fault reaction passes on to fault on the next step
   a_reaction_to_fault: assert property (@(posedge clock) disable iff (reset)
      (step.valid && step.cmd == REQ_STEP && state_ff == ST_REACTION)
      |=> (state_ff == ST_FAULT))
      else $error("fault reaction did not pass on to fault");

endmodule

### bench/testbench.sv
// self-checking testbench for the drive profile state machine top level
`timescale 1ns / 1ps

module testbench;
   import dpsm_pkg::*;

   localparam int IdleLimit  = 2000;
   localparam int PhaseItems = 230;
   localparam int MaxPrinted = 100;

   // single control word bits and the command words built from them
   localparam logic [CwWidth-1:0] BIT_SWITCH_ON = 16'h0001 << CwBitSwitchOn;
   localparam logic [CwWidth-1:0] BIT_VOLTAGE   = 16'h0001 << CwBitVoltage;
   localparam logic [CwWidth-1:0] BIT_QSTOP     = 16'h0001 << CwBitQstop;
   localparam logic [CwWidth-1:0] BIT_OPERATE   = 16'h0001 << CwBitOperate;
   localparam logic [CwWidth-1:0] BIT_RESET     = 16'h0001 << CwBitReset;
   localparam logic [CwWidth-1:0] CW_NONE       = 16'h0000;
   localparam logic [CwWidth-1:0] CW_ALL        = 16'hFFFF;
   localparam logic [CwWidth-1:0] CW_QUICKSTOP  = CMD_ENABLEOP & ~BIT_QSTOP;
   localparam logic [CwWidth-1:0] CW_QS_FROM_ON = BIT_VOLTAGE | BIT_SWITCH_ON;
   localparam logic [CwWidth-1:0] CW_VOLT_OFF   = BIT_QSTOP | BIT_SWITCH_ON;
   localparam logic [CwWidth-1:0] CW_FREE_BITS  = 16'hFF70;

   // expected results of the drive, worked out from each accepted request
   class drive_state_scoreboard;
      drive_state_type       state;
      logic                  prior_reset;
      logic signed [7:0]     mode;
      result_type            awaited_results[$];
      int                    errors;
      int                    results_seen;

      function new();
         state        = ST_DISABLED;
         prior_reset  = 1'b0;
         mode         = '0;
         errors       = 0;
         results_seen = 0;
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      function logic holds(logic [CwWidth-1:0] cw, logic [CwWidth-1:0] pat);
         return (cw & pat) == pat;
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= MaxPrinted)
            $display("mismatch on %s at result %0d: got %h, expected %h",
                     what, results_seen, got, want);
      endtask

      // next state and result of one request transaction
      function void note_request(logic cmd, logic [CwWidth-1:0] cw);
         drive_state_type nxt;
         logic            rst;
         result_type      r;
         rst = cw[CwBitReset];
         nxt = state;
         if (cmd == REQ_FAULT) begin
            nxt = ST_REACTION;
         end else begin
            case (state)
               ST_DISABLED: begin
                  if (holds(cw, CMD_SHUTDOWN)) nxt = ST_READY;
               end
               ST_READY: begin
                  if (!cw[CwBitVoltage]) nxt = ST_DISABLED;
                  else if (holds(cw, CMD_SWITCHON)) nxt = ST_ON;
               end
               ST_ON: begin
                  if (!cw[CwBitVoltage]) nxt = ST_DISABLED;
                  else if (!cw[CwBitQstop]) nxt = ST_QSTOP;
                  else if (holds(cw, CMD_ENABLEOP)) nxt = ST_ENABLED;
               end
               ST_ENABLED: begin
                  if (!cw[CwBitVoltage]) nxt = ST_DISABLED;
                  else if (!cw[CwBitQstop]) nxt = ST_QSTOP;
                  else if (!cw[CwBitOperate]) nxt = ST_ON;
               end
               // quick stop is left only by re-enabling or dropping voltage
               ST_QSTOP: begin
                  if (!cw[CwBitVoltage]) nxt = ST_DISABLED;
                  else if (holds(cw, CMD_ENABLEOP)) nxt = ST_ENABLED;
               end
               ST_REACTION: nxt = ST_FAULT;
               // fault clears only on a rising edge of the reset bit
               ST_FAULT: begin
                  if (rst && !prior_reset) nxt = ST_DISABLED;
               end
               default: nxt = state;
            endcase
            prior_reset = rst;
         end
         state = nxt;
         case (nxt)
            ST_NOTREADY: r.status_word = 16'h0000;
            ST_DISABLED: r.status_word = 16'h0050;
            ST_READY:    r.status_word = 16'h0011;
            ST_ON:       r.status_word = 16'h0013;
            ST_ENABLED:  r.status_word = 16'h0017;
            ST_QSTOP:    r.status_word = 16'h0017;
            ST_REACTION: r.status_word = 16'h0018;
            default:     r.status_word = 16'h0048;
         endcase
         r.drive_state    = nxt;
         r.output_enabled = (nxt == ST_ENABLED);
         r.active_mode    = mode;
         awaited_results.push_back(r);
      endfunction

      // compare one accepted result with the oldest expectation
      task check_result(logic [31:0] tdata);
         result_type want;
         results_seen++;
         if (awaited_results.size() == 0) begin
            report_mismatch("result with no request", tdata, '0);
            return;
         end
         want = awaited_results.pop_front();
         if (tdata[15:0] !== want.status_word)
            report_mismatch("status_word", tdata[15:0], want.status_word);
         if (tdata[18:16] !== want.drive_state)
            report_mismatch("drive_state", tdata[18:16], want.drive_state);
         if (tdata[19] !== want.output_enabled)
            report_mismatch("output_enabled", tdata[19], want.output_enabled);
         if (tdata[27:20] !== want.active_mode)
            report_mismatch("active_mode", tdata[27:20], want.active_mode);
         if (tdata[31:28] !== 4'h0)
            report_mismatch("padding", tdata[31:28], '0);
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tuser  = REQ_STEP;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [7:0]  csr_wdata  = '0;

   logic        no_idle    = 1'b0;
   int          idle_cycles = 0;

   drive_state_scoreboard sb = new();

   drive_profile_state_machine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // clock
   always #1 clock = ~clock;

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // result side with random stalls
   initial begin : receiver
      int gap;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         gap = no_idle ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         sb.check_result(rsp_tdata);
      end
   end

   // one request transaction after a random gap
   task send_item(input logic cmd, input logic [CwWidth-1:0] cw);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= cw;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.note_request(cmd, cw);
   endtask

   // hold off requests until every result is back and the block is quiet
   task drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_mode(input logic signed [7:0] value);
      drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.mode = value;
   endtask

   // mostly command sequences with random spare bits, some raw noise
   function automatic logic [CwWidth-1:0] pick_control_word();
      logic [CwWidth-1:0] cw;
      int sel;
      sel = $urandom_range(0, 15);
      case (sel)
         0, 1:   cw = CMD_SHUTDOWN;
         2, 3:   cw = CMD_SWITCHON;
         4, 5:   cw = CMD_ENABLEOP;
         6:      cw = CW_QUICKSTOP;
         7:      cw = CW_QS_FROM_ON;
         8:      cw = CW_VOLT_OFF;
         9:      cw = CW_NONE;
         10, 11: cw = BIT_RESET;
         12:     cw = CMD_ENABLEOP & ~BIT_OPERATE;
         default: cw = 16'($urandom);
      endcase
      if (sel < 13) begin
         if ($urandom_range(0, 1) == 1) cw = cw | (CW_FREE_BITS & 16'($urandom));
         if ($urandom_range(0, 5) == 0) cw = cw | BIT_RESET;
      end
      return cw;
   endfunction

   // walk through every reachable state and the corner transitions
   task run_directed;
      send_item(REQ_STEP,  CW_NONE);
      send_item(REQ_STEP,  CMD_SHUTDOWN);
      send_item(REQ_STEP,  CW_VOLT_OFF);
      send_item(REQ_STEP,  CMD_SHUTDOWN);
      send_item(REQ_STEP,  CMD_SWITCHON);
      send_item(REQ_STEP,  CMD_ENABLEOP);
      send_item(REQ_STEP,  CW_QUICKSTOP);
      // switch on and shutdown do not leave quick stop
      send_item(REQ_STEP,  CMD_SWITCHON);
      send_item(REQ_STEP,  CMD_SHUTDOWN);
      send_item(REQ_STEP,  CMD_ENABLEOP);
      send_item(REQ_STEP,  CMD_SWITCHON);
      send_item(REQ_STEP,  CW_QS_FROM_ON);
      send_item(REQ_STEP,  CW_NONE);
      send_item(REQ_STEP,  CW_ALL);
      // fault while the reset bit is already high: held bit does not clear
      send_item(REQ_FAULT, CW_ALL);
      send_item(REQ_STEP,  BIT_RESET);
      send_item(REQ_STEP,  BIT_RESET);
      send_item(REQ_FAULT, CW_NONE);
      send_item(REQ_STEP,  CW_NONE);
      send_item(REQ_STEP,  BIT_RESET);
      send_item(REQ_STEP,  CMD_SHUTDOWN);
      send_item(REQ_STEP,  CMD_SWITCHON);
      send_item(REQ_STEP,  CMD_ENABLEOP);
      send_item(REQ_FAULT, BIT_RESET);
      send_item(REQ_STEP,  CW_NONE);
   endtask

   // reset, then one phase per mode setting
   initial begin : stimulus
      logic signed [7:0] modes[6];
      modes[0] = 8'sd0;
      modes[1] = 8'sd127;
      modes[2] = -8'sd128;
      modes[3] = -8'sd1;
      modes[4] = 8'($urandom);
      modes[5] = 8'($urandom);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 6; phase++) begin
         write_mode(modes[phase]);
         if (phase == 0) run_directed();
         for (int n = 0; n < PhaseItems; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0) send_item(REQ_FAULT, 16'($urandom));
            else send_item(REQ_STEP, pick_control_word());
         end
      end
      drain();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch("results never delivered", sb.pending(), '0);
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
